@@ rtl/rpn_pkg.sv @@
// Package for the RPN stack calculator: operator codes, status codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package rpn_pkg;
	localparam logic [2:0] FUNC_PUSH = 3'd0;
	localparam logic [2:0] FUNC_ADD  = 3'd1;
	localparam logic [2:0] FUNC_SUB  = 3'd2;
	localparam logic [2:0] FUNC_MUL  = 3'd3;
	localparam logic [2:0] FUNC_DIV  = 3'd4;
	localparam logic [2:0] FUNC_POW  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_DIVZ  = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam int CNT_W = 7;

	// datapath commands from the controller
	typedef struct packed {
		logic       load_in;   // latch func/operand
		logic       pop;       // read top entry, decrement count
		logic       take_b;    // popped word goes to b (else a)
		logic       start;     // start the arithmetic unit
		logic       push_res;  // write result, increment count
		logic       push_opnd; // write operand
		logic       rd_top;    // read new top for the result beat
	} rpn_cmd_t;

	typedef struct packed {
		logic       busy;      // arithmetic unit working
		logic       empty;
		logic       ge2;
		logic       full;
	} rpn_stat_t;
endpackage

@@ rtl/rpn_if.sv @@
// Valid/ready channel interface with a generic payload type.
// Depends on nothing.
`timescale 1ns / 1ps
interface rpn_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/rpn_alu.sv @@
// Multi-cycle arithmetic unit: add, sub, shift-add multiply, restoring divide, power.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_alu import rpn_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       func,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic             busy,
	output logic [WIDTH-1:0] res
);
	localparam int SW = $clog2(WIDTH + 1);
	localparam logic [SW-1:0] STEPS = SW'(WIDTH);

	logic             busy_q;
	logic [SW-1:0]    cnt_q;
	logic [2:0]       func_q;
	logic [WIDTH-1:0] res_q, acc_q, x_q, y_q, rem_q;
	logic             neg_q;
	// power: two multiplies per bit, phase_q picks which
	logic             phase_q;

	logic [WIDTH:0]   rem_sh;
	logic [WIDTH-1:0] mag_a, mag_b, prod;
	logic [WIDTH-1:0] mul_x, mul_y;

	assign mag_a = a[WIDTH-1] ? (~a + 1'b1) : a;
	assign mag_b = b[WIDTH-1] ? (~b + 1'b1) : b;
	assign rem_sh = {rem_q, x_q[WIDTH-1]};
	assign mul_x = phase_q ? y_q : acc_q;
	assign prod = mul_x * y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			phase_q <= 1'b0;
		end else if (start) begin
			phase_q <= 1'b0;
			cnt_q <= STEPS;
			busy_q <= (func == FUNC_MUL) || (func == FUNC_DIV) ||
				((func == FUNC_POW) && !b[WIDTH-1]);
		end else if (busy_q) begin
			if (func_q == FUNC_POW) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == SW'(1)) busy_q <= 1'b0;
				end
			end else begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			func_q <= func;
			rem_q <= '0;
			neg_q <= a[WIDTH-1] ^ b[WIDTH-1];
			case (func)
				FUNC_ADD: res_q <= a + b;
				FUNC_SUB: res_q <= a - b;
				FUNC_MUL: begin
					acc_q <= '0;
					x_q <= b;
					y_q <= a;
				end
				FUNC_DIV: begin
					x_q <= mag_a;
					y_q <= mag_b;
				end
				FUNC_POW: begin
					acc_q <= WIDTH'(1);
					x_q <= b;
					y_q <= a;
					if (a == WIDTH'(1)) res_q <= WIDTH'(1);
					else if (a == '1) res_q <= b[0] ? '1 : WIDTH'(1);
					else res_q <= '0;
				end
				default: res_q <= '0;
			endcase
		end else if (busy_q) begin
			case (func_q)
				FUNC_MUL: begin
					// shift-add, one multiplier bit per cycle
					if (x_q[0]) acc_q <= acc_q + y_q;
					x_q <= x_q >> 1;
					y_q <= y_q << 1;
					res_q <= x_q[0] ? acc_q + y_q : acc_q;
				end
				FUNC_DIV: begin
					// restoring division, one quotient bit per cycle
					if (rem_sh >= {1'b0, y_q}) begin
						rem_q <= WIDTH'(rem_sh - {1'b0, y_q});
						x_q <= {x_q[WIDTH-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[WIDTH-1:0];
						x_q <= {x_q[WIDTH-2:0], 1'b0};
					end
					res_q <= neg_q ?
						~{x_q[WIDTH-2:0], rem_sh >= {1'b0, y_q}} + 1'b1 :
						{x_q[WIDTH-2:0], rem_sh >= {1'b0, y_q}};
				end
				FUNC_POW: begin
					if (!phase_q) begin
						if (x_q[0]) acc_q <= prod;
					end else begin
						y_q <= prod;
						x_q <= x_q >> 1;
					end
					res_q <= (!phase_q && x_q[0]) ? prod : acc_q;
				end
				default: res_q <= res_q;
			endcase
		end
	end

	assign busy = busy_q;
	assign res = res_q;
endmodule

@@ rtl/rpn_datapath.sv @@
// Stack datapath: value memory, fill count, operand registers and arithmetic unit.
// Depends on rpn_pkg and rpn_alu.
`timescale 1ns / 1ps
module rpn_datapath import rpn_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rpn_cmd_t         cmd,
	input  logic [2:0]       func,
	input  logic [WIDTH-1:0] operand,
	output rpn_stat_t        stat,
	output logic [2:0]       func_out,
	output logic [WIDTH-1:0] top_value,
	output logic [CNT_W-1:0] stack_count,
	output logic             b_zero
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [CW-1:0]    cnt_q;
	logic [2:0]       func_q;
	logic [WIDTH-1:0] opnd_q, a_q, b_q, rd_q;
	logic             alu_busy;
	logic [WIDTH-1:0] alu_res;
	logic [CW-1:0]    rd_idx;

	assign rd_idx = cnt_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.pop && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.push_res || cmd.push_opnd) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func;
			opnd_q <= operand;
			a_q <= '0;
			b_q <= '0;
		end
		if (cmd.pop && cnt_q != '0) begin
			if (cmd.take_b) b_q <= mem[rd_idx[AW-1:0]];
			else a_q <= mem[rd_idx[AW-1:0]];
		end
		if (cmd.push_res) mem[cnt_q[AW-1:0]] <= (b_q == '0 && func_q == FUNC_DIV) ? '0 : alu_res;
		if (cmd.push_opnd) mem[cnt_q[AW-1:0]] <= opnd_q;
		if (cmd.rd_top) rd_q <= (cnt_q == '0) ? '0 : mem[rd_idx[AW-1:0]];
	end

	rpn_alu #(.WIDTH(WIDTH)) u_alu (
		.clk(clk), .arst_n(arst_n), .start(cmd.start), .func(func_q),
		.a(a_q), .b(b_q), .busy(alu_busy), .res(alu_res)
	);

	assign stat.busy = alu_busy;
	assign stat.empty = (cnt_q == '0);
	assign stat.ge2 = (cnt_q >= CW'(2));
	assign stat.full = (cnt_q == CW'(DEPTH));
	assign func_out = func_q;
	assign b_zero = (b_q == '0);
	assign top_value = rd_q;
	assign stack_count = CNT_W'(cnt_q);
endmodule

@@ rtl/rpn_ctrl.sv @@
// Controller state machine: sequences pops, arithmetic, push and result beat.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_ctrl import rpn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  rpn_stat_t  stat,
	input  logic [2:0] func,
	input  logic       b_zero,
	output rpn_cmd_t   cmd,
	output logic [1:0] status
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_POPA  = 3'd2;
	localparam logic [2:0] S_START = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd4;
	localparam logic [2:0] S_TOP   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [1:0] status_q;

	always_comb begin
		cmd = '0;
		cmd.load_in = (state_q == S_IDLE) && in_valid;
		case (state_q)
			S_DEC: if (func >= FUNC_ADD && func <= FUNC_POW) begin
				cmd.pop = 1'b1;
				cmd.take_b = 1'b1;
			end else if (func == FUNC_PUSH && !stat.full) begin
				cmd.push_opnd = 1'b1;
			end
			S_POPA:  cmd.pop = 1'b1;
			S_START: cmd.start = 1'b1;
			S_WAIT:  cmd.push_res = !stat.busy;
			S_TOP:   cmd.rd_top = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DEC;
				S_DEC: begin
					if (func >= FUNC_ADD && func <= FUNC_POW) begin
						status_q <= stat.ge2 ? ST_OK : ST_UNDER;
						state_q <= S_POPA;
					end else begin
						status_q <= (func == FUNC_PUSH && stat.full) ? ST_FULL : ST_OK;
						state_q <= S_TOP;
					end
				end
				S_POPA:  state_q <= S_START;
				S_START: begin
					if (func == FUNC_DIV && b_zero && status_q == ST_OK) status_q <= ST_DIVZ;
					state_q <= S_WAIT;
				end
				S_WAIT:  if (!stat.busy) state_q <= S_TOP;
				S_TOP:   state_q <= S_OUT;
				S_OUT:   if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = status_q;
endmodule

@@ rtl/rpn_stack_calculator_top.sv @@
// Top level of the RPN stack calculator: controller plus stack datapath.
// Depends on rpn_pkg, rpn_if, rpn_ctrl, rpn_datapath.
//
// Usage: in_ch carries {func, operand}; one beat gives exactly one beat on out_ch
// carrying {top_value, stack_count, status}. Push and unused codes pass decode
// and top read before the result beat; arithmetic codes also pop b and a, start
// the arithmetic unit and wait while it is busy, then push the result. Multiply
// and divide go bit by bit; square and multiply for power share one multiplier,
// taking turns per exponent bit. Negative exponents finish at once.
// An item holds the block until its result beat is taken; then the block is idle.
// The multi-cycle arithmetic unit sets the item rate; one item is in flight at
// a time and in_ch.ready is high only while idle.
// Reset clears the fill count and the controller; the value memory is not
// cleared and entries are read only below the fill count.
// When the receiver stalls the result beat holds and no new input is taken.
`timescale 1ns / 1ps
module rpn_stack_calculator_top import rpn_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	rpn_if.sink   in_ch,
	rpn_if.source out_ch
);
	rpn_cmd_t   cmd;
	rpn_stat_t  stat;
	logic [2:0] func_r;
	logic       b_zero;
	logic [1:0] status;
	logic [WIDTH-1:0] top_value;
	logic [CNT_W-1:0] stack_count;

	rpn_datapath #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.func(in_ch.data.func), .operand(in_ch.data.operand),
		.stat(stat), .func_out(func_r), .top_value(top_value),
		.stack_count(stack_count), .b_zero(b_zero)
	);

	rpn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .stat(stat),
		.func(func_r), .b_zero(b_zero), .cmd(cmd), .status(status)
	);

	assign out_ch.data.top_value = top_value;
	assign out_ch.data.stack_count = stack_count;
	assign out_ch.data.status = status;
endmodule
